// ===== rtl/adgr_pkg.sv =====
// Shared types and constants for the AdaGrad parameter update block.
`default_nettype none
package adgr_pkg;

	localparam logic [1:0] CMD_WEIGHT = 2'd0;
	localparam logic [1:0] CMD_BIAS   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic CFG_LR  = 1'b0;
	localparam logic CFG_EPS = 1'b1;

	localparam logic [31:0] LR_RESET  = 32'd167772;
	localparam logic [31:0] EPS_RESET = 32'd2814750;

	localparam int SQRT_STEPS = 32;
	localparam int QBITS      = 35;

	localparam logic [QBITS-1:0] STEP_MAX = 35'h400000000;

	typedef struct packed {
		logic               bypass;
		logic               gneg;
		logic               sat;
		logic signed [31:0] win;
	} side_t;

endpackage
`default_nettype wire

// ===== rtl/adgr_if.sv =====
// Stream interfaces for update items and result items.
`default_nettype none
interface adgr_upd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [5:0]         neuron_index;
	logic [5:0]         input_index;
	logic signed [31:0] weight_in;
	logic signed [31:0] gradient;

	modport source (output valid, cmd, neuron_index, input_index, weight_in, gradient,
		input ready);
	modport sink (input valid, cmd, neuron_index, input_index, weight_in, gradient,
		output ready);
endinterface

interface adgr_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] weight_out;
	logic               saturated;

	modport source (output valid, weight_out, saturated, input ready);
	modport sink (input valid, weight_out, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/adgr_isqrt.sv =====
// Pipelined 64-bit integer square root, one result bit per stage.
`default_nettype none
module adgr_isqrt (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_v,
	input  wire logic [63:0]     den,
	input  wire logic [63:0]     num,
	input  wire adgr_pkg::side_t side_i,
	output logic                 out_v,
	output logic [31:0]          root,
	output logic [63:0]          num_o,
	output adgr_pkg::side_t      side_o
);
	import adgr_pkg::*;

	logic        v_q    [SQRT_STEPS+1];
	logic [63:0] rem_q  [SQRT_STEPS+1];
	logic [63:0] root_q [SQRT_STEPS+1];
	logic [63:0] num_q  [SQRT_STEPS+1];
	side_t       side_q [SQRT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= den;
			root_q[0] <= '0;
			num_q[0]  <= num;
			side_q[0] <= side_i;
		end
	end

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial;
		logic [63:0] rem_n;
		logic [63:0] root_n;

		assign trial = root_q[i] + BIT;

		// take the bit when the remainder covers the trial value
		always_comb begin
			if (rem_q[i] >= trial) begin
				rem_n  = rem_q[i] - trial;
				root_n = (root_q[i] >> 1) + BIT;
			end else begin
				rem_n  = rem_q[i];
				root_n = root_q[i] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1]  <= rem_n;
				root_q[i+1] <= root_n;
				num_q[i+1]  <= num_q[i];
				side_q[i+1] <= side_q[i];
			end
		end
	end

	assign out_v  = v_q[SQRT_STEPS];
	assign root   = root_q[SQRT_STEPS][31:0];
	assign num_o  = num_q[SQRT_STEPS];
	assign side_o = side_q[SQRT_STEPS];

endmodule
`default_nettype wire

// ===== rtl/adgr_div.sv =====
// Pipelined rounded divide of the step numerator by the root, clamped step.
`default_nettype none
module adgr_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_v,
	input  wire logic [63:0]     num,
	input  wire logic [31:0]     root,
	input  wire adgr_pkg::side_t side_i,
	output logic                 out_v,
	output logic [34:0]          step,
	output adgr_pkg::side_t      side_o
);
	import adgr_pkg::*;

	localparam int NS = QBITS + 2;

	logic             v_q    [NS];
	logic [64:0]      rem_q  [NS];
	logic [31:0]      root_q [NS];
	logic [QBITS-1:0] q_q    [NS];
	logic             ovf_q  [NS];
	logic             zero_q [NS];
	side_t            side_q [NS];

	// stage 0: add half the divisor for round to nearest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
			v_q[1] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_v;
			v_q[1] <= v_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= {1'b0, num} + 65'(root >> 1);
			root_q[0] <= root;
			q_q[0]    <= '0;
			ovf_q[0]  <= 1'b0;
			zero_q[0] <= (root == 32'd0);
			side_q[0] <= side_i;
			// stage 1: flag quotients that cannot fit the quotient bits
			rem_q[1]  <= rem_q[0];
			root_q[1] <= root_q[0];
			q_q[1]    <= '0;
			ovf_q[1]  <= (rem_q[0] >> QBITS) >= 65'(root_q[0]);
			zero_q[1] <= zero_q[0];
			side_q[1] <= side_q[0];
		end
	end

	for (genvar j = 1; j <= QBITS; j++) begin : g_step
		localparam int B = QBITS - j;
		logic [66:0] dshift;
		logic        ge;

		assign dshift = 67'(root_q[j]) << B;
		assign ge     = {2'b00, rem_q[j]} >= dshift;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j+1] <= 1'b0;
			end else if (en) begin
				v_q[j+1] <= v_q[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j+1]  <= ge ? 65'({2'b00, rem_q[j]} - dshift) : rem_q[j];
				q_q[j+1]    <= ge ? (q_q[j] | (QBITS'(1) << B)) : q_q[j];
				root_q[j+1] <= root_q[j];
				ovf_q[j+1]  <= ovf_q[j];
				zero_q[j+1] <= zero_q[j];
				side_q[j+1] <= side_q[j];
			end
		end
	end

	always_comb begin
		if (zero_q[NS-1]) begin
			step = '0;
		end else if (ovf_q[NS-1] || (q_q[NS-1] > STEP_MAX)) begin
			step = STEP_MAX;
		end else begin
			step = q_q[NS-1];
		end
	end

	assign out_v  = v_q[NS-1];
	assign side_o = side_q[NS-1];

endmodule
`default_nettype wire

// ===== rtl/adagrad_parameter_update_top.sv =====
// Top level of the AdaGrad parameter update block.
//
// Usage: update transactions arrive on upd (valid/ready); cmd selects a
// weight update, a bias update or a clear of all squared-gradient
// accumulators. Every weight or bias transaction yields one result
// transaction on res with the updated value and a saturation flag; clear
// and the unused command yield none. The user must write the step scale and
// epsilon through cfg_we / cfg_index / cfg_wdata only while the block is idle.
// Throughput: one transaction per cycle while res is not stalled and no
// clear sweep runs; the accumulators live in one synchronous memory read at
// accept and written back from the accumulate stage, with forwarding
// between back-to-back updates of the same entry.
// Reset and clear: the accumulator memory holds MAX_NEURONS*MAX_INPUTS +
// MAX_NEURONS entries (4160 by default) and is zeroed by a sweep of one
// entry per cycle, after reset and after each clear command; upd.ready is
// low for the length of the sweep. Configuration writes are taken anytime.
// Stall: the whole pipeline holds while res is valid and res.ready is low;
// upd.ready drops with it.
`default_nettype none
module adagrad_parameter_update_top #(
	parameter int MAX_NEURONS = 64,
	parameter int MAX_INPUTS  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	adgr_upd_if.sink         upd,
	adgr_res_if.source       res,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	import adgr_pkg::*;

	localparam int BIAS_BASE = MAX_NEURONS * MAX_INPUTS;
	localparam int DEPTH     = BIAS_BASE + MAX_NEURONS;
	localparam int AW        = $clog2(DEPTH);

	// configuration registers
	logic [31:0] lr_q;
	logic [31:0] eps_q;

	// clear sweep
	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;
	logic          sweep_go;

	// accumulator memory
	logic [63:0]   mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [63:0]   mem_wd;

	// accept path
	logic          en;
	logic          acc_go;
	logic          is_upd;
	logic          oor;
	logic [AW-1:0] addr_c;
	logic [31:0]   g_u;
	logic [31:0]   gmag_c;
	logic [63:0]   sq_c;

	// stage 1: memory data arrives, accumulate
	logic          v_s1;
	logic [AW-1:0] addr_s1;
	logic [63:0]   sq_s1;
	logic [31:0]   gmag_s1;
	side_t         side_s1;
	logic [63:0]   rd_s1;
	logic          fwd;
	logic [63:0]   acc_old;
	logic [64:0]   acc_sum;
	logic [63:0]   acc_new;
	logic          upd_we;

	// stage 2: add epsilon, form the step numerator
	logic          v_s2;
	logic [AW-1:0] addr_s2;
	logic          fwd_ok_s2;
	logic [63:0]   acc_s2;
	logic [31:0]   gmag_s2;
	side_t         side_s2;
	logic [64:0]   den_sum;
	logic [63:0]   den_c;
	logic [63:0]   num_c;

	// root and divide pipelines
	logic          v_r;
	logic [31:0]   root_r;
	logic [63:0]   num_r;
	side_t         side_r;
	logic          v_d;
	logic [34:0]   step_d;
	side_t         side_d;

	// result
	logic signed [35:0] wext;
	logic signed [35:0] sext;
	logic signed [35:0] r_c;
	logic               rsat;
	logic               out_v_q;
	logic signed [31:0] weight_out_q;
	logic               sat_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LR_RESET;
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LR:  lr_q  <= cfg_wdata;
				CFG_EPS: eps_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// advance the pipeline unless a finished result is waiting
	assign en        = !out_v_q || res.ready;
	assign upd.ready = en && !clr_busy_q;
	assign acc_go    = upd.valid && upd.ready;

	assign is_upd = (upd.cmd == CMD_WEIGHT) || (upd.cmd == CMD_BIAS);
	assign oor    = (32'(upd.neuron_index) >= MAX_NEURONS)
		|| ((upd.cmd == CMD_WEIGHT) && (32'(upd.input_index) >= MAX_INPUTS));
	assign addr_c = (upd.cmd == CMD_WEIGHT)
		? AW'(32'(upd.neuron_index) * 32'(MAX_INPUTS) + 32'(upd.input_index))
		: AW'(BIAS_BASE + 32'(upd.neuron_index));

	assign g_u    = upd.gradient;
	assign gmag_c = g_u[31] ? (~g_u + 32'd1) : g_u;
	assign sq_c   = 64'(gmag_c) * 64'(gmag_c);

	// sweep only once the accumulate stage has drained; an update there
	// belongs before the clear and must be zeroed by the sweep
	assign sweep_go = clr_busy_q && !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (acc_go && (upd.cmd == CMD_CLEAR)) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (sweep_go) begin
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// memory port: sweep and write-back never meet
	assign upd_we = en && v_s1 && !side_s1.bypass;
	assign mem_we = sweep_go || upd_we;
	assign mem_wa = sweep_go ? clr_cnt_q : addr_s1;
	assign mem_wd = sweep_go ? 64'd0 : acc_new;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (acc_go) begin
			rd_s1 <= mem[addr_c];
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc_go && is_upd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1        <= addr_c;
			sq_s1          <= sq_c;
			gmag_s1        <= gmag_c;
			side_s1.bypass <= oor;
			side_s1.gneg   <= g_u[31];
			side_s1.sat    <= 1'b0;
			side_s1.win    <= upd.weight_in;
		end
	end

	// the item ahead wrote its entry at the edge this one was read
	assign fwd     = v_s2 && fwd_ok_s2 && (addr_s2 == addr_s1);
	assign acc_old = fwd ? acc_s2 : rd_s1;
	assign acc_sum = {1'b0, acc_old} + {1'b0, sq_s1};
	assign acc_new = acc_sum[64] ? '1 : acc_sum[63:0];

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			fwd_ok_s2 <= 1'b0;
		end else if (en) begin
			v_s2      <= v_s1;
			fwd_ok_s2 <= v_s1 && !side_s1.bypass;
		end else if (clr_busy_q) begin
			// drop a stale forward across a clear
			fwd_ok_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s2        <= addr_s1;
			acc_s2         <= acc_new;
			gmag_s2        <= gmag_s1;
			side_s2.bypass <= side_s1.bypass;
			side_s2.gneg   <= side_s1.gneg;
			side_s2.sat    <= acc_sum[64];
			side_s2.win    <= side_s1.win;
		end
	end

	assign den_sum = {1'b0, acc_s2} + 65'(eps_q);
	assign den_c   = den_sum[64] ? '1 : den_sum[63:0];
	assign num_c   = 64'(lr_q) * 64'(gmag_s2);

	adgr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.den    (den_c),
		.num    (num_c),
		.side_i (side_s2),
		.out_v  (v_r),
		.root   (root_r),
		.num_o  (num_r),
		.side_o (side_r)
	);

	adgr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_r),
		.num    (num_r),
		.root   (root_r),
		.side_i (side_r),
		.out_v  (v_d),
		.step   (step_d),
		.side_o (side_d)
	);

	// apply the step against the gradient sign and clamp to 32 bits
	assign wext = 36'(side_d.win);
	assign sext = $signed({1'b0, step_d});
	assign r_c  = side_d.gneg ? (wext + sext) : (wext - sext);
	assign rsat = (r_c[35:31] != 5'b00000) && (r_c[35:31] != 5'b11111);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_d.bypass) begin
				weight_out_q <= side_d.win;
				sat_q        <= 1'b0;
			end else if (rsat) begin
				weight_out_q <= r_c[35] ? 32'sh80000000 : 32'sh7FFFFFFF;
				sat_q        <= 1'b1;
			end else begin
				weight_out_q <= r_c[31:0];
				sat_q        <= side_d.sat;
			end
		end
	end

	assign res.valid      = out_v_q;
	assign res.weight_out = weight_out_q;
	assign res.saturated  = sat_q;

endmodule
`default_nettype wire

// ===== bench/adagrad_parameter_update_top_tb.sv =====
// Self-checking testbench for the AdaGrad parameter update block.
`timescale 1ns / 100ps
`default_nettype none

module adagrad_parameter_update_top_tb;
	import adgr_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         SETTLE     = 80;

	// Predict the updated weights; hold the expected results in arrival order.
	class weight_update_model;
		logic [31:0] lr;
		logic [31:0] eps;
		logic [63:0] w_acc [4096];
		bit          w_live [4096];
		logic [63:0] b_acc [64];
		bit          b_live [64];
		logic [32:0] pending_weights [$];
		int          faults;
		int          checked;

		function new();
			lr = LR_RESET;
			eps = EPS_RESET;
			foreach (w_live[i]) w_live[i] = 0;
			foreach (b_live[i]) b_live[i] = 0;
			faults = 0;
			checked = 0;
		endfunction

		function logic [63:0] isqrt(logic [63:0] x);
			logic [63:0] rem, root, b;
			rem = x;
			root = 0;
			b = 64'd1 << 62;
			while (b > rem) b = b >> 2;
			while (b != 0) begin
				if (rem >= root + b) begin
					rem = rem - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		function void note_update(logic [1:0] c, logic [5:0] n, logic [5:0] k,
				logic signed [31:0] w, logic signed [31:0] g);
			logic [31:0] gm32;
			logic [63:0] gm, acc, sq, den, root, num, step;
			longint      r;
			bit          sat;
			int          idx;
			if (c == CMD_CLEAR) begin
				foreach (w_live[i]) w_live[i] = 0;
				foreach (b_live[i]) b_live[i] = 0;
				return;
			end
			if (c == CMD_UNUSED) return;
			sat = 0;
			gm32 = g[31] ? -g : g;
			gm = {32'd0, gm32};
			idx = {n, k};
			if (c == CMD_WEIGHT) acc = w_live[idx] ? w_acc[idx] : 64'd0;
			else acc = b_live[n] ? b_acc[n] : 64'd0;
			sq = gm * gm;
			if (acc > ~64'd0 - sq) begin
				acc = ~64'd0;
				sat = 1;
			end else begin
				acc = acc + sq;
			end
			if (c == CMD_WEIGHT) begin
				w_acc[idx] = acc;
				w_live[idx] = 1;
			end else begin
				b_acc[n] = acc;
				b_live[n] = 1;
			end
			den = (acc > ~64'd0 - {32'd0, eps}) ? ~64'd0 : acc + {32'd0, eps};
			root = isqrt(den);
			num = {32'd0, lr} * gm;
			step = (root == 0) ? 64'd0 : (num + (root >> 1)) / root;
			if (step > (64'd1 << 34)) step = 64'd1 << 34;
			r = g[31] ? longint'(w) + longint'(step) : longint'(w) - longint'(step);
			if (r > 64'sh7FFFFFFF) begin
				r = 64'sh7FFFFFFF;
				sat = 1;
			end else if (r < -64'sh80000000) begin
				r = -64'sh80000000;
				sat = 1;
			end
			pending_weights.push_back({sat, r[31:0]});
		endfunction

		function void check_result(logic signed [31:0] wo, logic s);
			logic [32:0] exp_res;
			checked++;
			if (pending_weights.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: unexpected result weight_out=%h saturated=%b", $realtime, wo, s);
				return;
			end
			exp_res = pending_weights.pop_front();
			if (exp_res[31:0] !== wo || exp_res[32] !== s) begin
				faults++;
				if (faults <= 10)
					$display("%0t: mismatch weight_out exp %h got %h, saturated exp %b got %b",
						$realtime, exp_res[31:0], wo, exp_res[32], s);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_wdata;
	int          send_idle;
	int          recv_idle;
	int          n_sent;
	weight_update_model model;

	adgr_upd_if upd ();
	adgr_res_if res ();

	adagrad_parameter_update_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd.sink),
		.res       (res.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at random; the rate follows the current phase.
	always @(negedge clk) begin
		res.ready = ($urandom_range(99) >= recv_idle);
	end

	// Check every result transaction against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			model.check_result(res.weight_out, res.saturated);
	end

	// Drive one update transaction; idle first at random, then hold until accepted.
	task automatic send_update(input logic [1:0] c, input logic [5:0] n, input logic [5:0] k,
			input logic signed [31:0] w, input logic signed [31:0] g);
		while ($urandom_range(99) < send_idle) begin
			upd.valid = 0;
			@(negedge clk);
		end
		upd.valid = 1;
		upd.cmd = c;
		upd.neuron_index = n;
		upd.input_index = k;
		upd.weight_in = w;
		upd.gradient = g;
		@(posedge clk);
		while (!upd.ready) @(posedge clk);
		model.note_update(c, n, k, w, g);
		n_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result is in, then let the pipe settle.
	task automatic drain();
		upd.valid = 0;
		while (model.pending_weights.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 0;
		if (idx == CFG_LR) model.lr = val;
		else model.eps = val;
	endtask

	// Mix zero, tiny, extreme and full-range gradients so accumulators grow and saturate.
	function automatic logic signed [31:0] rand_grad();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10) return 0;
		if (sel < 35) return $urandom_range(1, 255) * ($urandom_range(1) ? 1 : -1);
		if (sel < 50) return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
		return $urandom;
	endfunction

	function automatic logic signed [31:0] rand_weight();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10) return 32'sh7FFFFFF0 + $urandom_range(15);
		if (sel < 20) return 32'sh80000000 + $urandom_range(15);
		return $urandom;
	endfunction

	task automatic random_items(input int count);
		int          sel;
		logic [1:0]  c;
		logic [5:0]  n, k;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(199);
			if (sel < 2) c = CMD_CLEAR;
			else if (sel < 6) c = CMD_UNUSED;
			else if (sel < 140) c = CMD_WEIGHT;
			else c = CMD_BIAS;
			// Reuse a small pool most of the time so entries see repeated updates.
			if ($urandom_range(99) < 70) begin
				n = 6'($urandom_range(3));
				k = 6'($urandom_range(3));
			end else begin
				n = 6'($urandom);
				k = 6'($urandom);
			end
			send_update(c, n, k, rand_weight(), rand_grad());
		end
	endtask

	initial begin
		model = new();
		n_sent = 0;
		send_idle = 12;
		recv_idle = 75;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_LR;
		cfg_wdata = 0;
		upd.valid = 0;
		upd.cmd = CMD_WEIGHT;
		upd.neuron_index = 0;
		upd.input_index = 0;
		upd.weight_in = 0;
		upd.gradient = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;

		// Directed: field extremes, every command, bias, unused command.
		send_update(CMD_WEIGHT, 6'd0, 6'd0, 32'sh7FFFFFFF, 32'sh80000000);
		send_update(CMD_WEIGHT, 6'd63, 6'd63, 32'sh80000000, 32'sh7FFFFFFF);
		send_update(CMD_BIAS, 6'd63, 6'd17, 32'sh01000000, 32'sh00000001);
		send_update(CMD_BIAS, 6'd0, 6'd0, 32'sh0, 32'shFFFFFFFF);
		send_update(CMD_UNUSED, 6'd5, 6'd5, 32'sh12345678, 32'sh1234);
		send_update(CMD_WEIGHT, 6'd1, 6'd2, 32'sh0, 32'sh0);
		// Hit one entry with the largest gradient until the accumulator clamps.
		for (int i = 0; i < 5; i++)
			send_update(CMD_WEIGHT, 6'd10, 6'd10, 32'sh0, 32'sh80000000);
		for (int i = 0; i < 5; i++)
			send_update(CMD_BIAS, 6'd20, 6'd0, 32'sh0, 32'sh80000000);
		send_update(CMD_CLEAR, 6'd0, 6'd0, 32'sh0, 32'sh0);
		send_update(CMD_WEIGHT, 6'd10, 6'd10, 32'sh7FFFFFFF, 32'shFFFFFFFF);
		send_update(CMD_BIAS, 6'd20, 6'd0, 32'sh80000000, 32'sh00000001);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle = 12;
				recv_idle = 75;
			end else if (ph < 4) begin
				send_idle = 75;
				recv_idle = 12;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (ph > 0) begin
				drain();
				case (ph)
					1: begin
						write_reg(CFG_LR, 32'hFFFFFFFF);
						write_reg(CFG_EPS, 32'h0);
					end
					2: begin
						write_reg(CFG_LR, 32'h0);
						write_reg(CFG_EPS, 32'hFFFFFFFF);
					end
					4: begin
						write_reg(CFG_LR, 32'h01000000);
						write_reg(CFG_EPS, 32'h1);
					end
					default: begin
						write_reg(CFG_LR, $urandom);
						write_reg(CFG_EPS, $urandom);
					end
				endcase
			end
			if (ph == 1) begin
				// Zero epsilon on a fresh entry with zero gradient gives a zero root.
				send_update(CMD_CLEAR, 6'd0, 6'd0, 32'sh0, 32'sh0);
				send_update(CMD_WEIGHT, 6'd7, 6'd7, 32'sh00ABCDEF, 32'sh0);
				send_update(CMD_BIAS, 6'd7, 6'd0, 32'sh7FFFFF00, 32'shFFFFFFFF);
				send_update(CMD_WEIGHT, 6'd8, 6'd8, 32'sh80000100, 32'sh00000001);
			end
			random_items(180);
		end

		drain();
		$display("Covered %0d update transactions and %0d results over six phases", n_sent,
			model.checked);
		$display("of learning rate, epsilon and handshake stall settings; %0d mismatches.",
			model.faults);
		if (model.faults == 0 && model.pending_weights.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Bound the run well past the slowest legal completion.
	initial begin
		#20ms;
		$display("Timeout with %0d results outstanding", model.pending_weights.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/adgr_pkg.sv
rtl/adgr_if.sv
rtl/adgr_isqrt.sv
rtl/adgr_div.sv
rtl/adagrad_parameter_update_top.sv
bench/adagrad_parameter_update_top_tb.sv
